FILE: design/lpht_pkg.sv
package lpht_pkg;

  localparam int TABLE_SIZE = 32;
  localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int KEY_W      = 31;
  localparam int VAL_W      = 32;
  localparam int SLOT_W     = 5;

  typedef enum logic [1:0] {
    OP_SEARCH = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_USED  = 2'd1,
    MARK_TOMB  = 2'd2
  } mark_t;

  typedef enum logic {
    S_IDLE,
    S_PROBE
  } state_t;

  typedef struct packed {
    mark_t             mark;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } slot_t;

  localparam int SLOT_BITS = $bits(slot_t);

endpackage

FILE: design/lpht_if.sv
interface lpht_in_if import lpht_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              operation;
  logic [KEY_W-1:0]        lookup_key;
  logic signed [VAL_W-1:0] entry_value;

  modport source (output valid, output operation, output lookup_key, output entry_value,
                  input ready);
  modport sink   (input valid, input operation, input lookup_key, input entry_value,
                  output ready);
endinterface

interface lpht_out_if import lpht_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic [KEY_W-1:0]        found_key;
  logic signed [VAL_W-1:0] found_value;
  logic [SLOT_W-1:0]       slot_index;

  modport source (output valid, output status, output found_key, output found_value,
                  output slot_index, input ready);
  modport sink   (input valid, input status, input found_key, input found_value,
                  input slot_index, output ready);
endinterface

FILE: design/lpht_ram.sv
module lpht_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold the last read word while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/lpht_ctrl.sv
module lpht_ctrl import lpht_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  lpht_in_if.sink              in_chan,
  lpht_out_if.source           out_chan,
  output logic                 ram_we,
  output logic [IDX_W-1:0]     ram_waddr,
  output slot_t                ram_wdata,
  output logic                 ram_re,
  output logic [IDX_W-1:0]     ram_raddr,
  input  slot_t                ram_rdata
);

  state_t                  state_r, state_nxt;
  op_t                     op_r;
  logic [KEY_W-1:0]        key_r;
  logic [VAL_W-1:0]        val_r;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [IDX_W-1:0]        cnt_r, cnt_nxt;
  logic [TABLE_SIZE-1:0]   vld_r;
  logic                    rd_vld_r;

  logic                    out_valid_r;
  status_t                 out_status_r;
  logic [KEY_W-1:0]        out_key_r;
  logic [VAL_W-1:0]        out_val_r;
  logic [SLOT_W-1:0]       out_slot_r;

  logic                    accept;
  logic                    out_free;
  logic                    finish;
  logic                    advance;
  logic                    wr_slot;
  mark_t                   wr_mark;
  status_t                 res_status;
  logic                    res_hit;
  mark_t                   rd_mark;
  logic                    last;
  logic [IDX_W-1:0]        idx_inc;
  logic [IDX_W-1:0]        home;

  assign home     = IDX_W'(in_chan.lookup_key % TABLE_SIZE);
  assign accept   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  // a slot never written reads as empty
  assign rd_mark  = rd_vld_r ? ram_rdata.mark : MARK_EMPTY;
  assign last     = (cnt_r == IDX_W'(TABLE_SIZE - 1));
  assign idx_inc  = (idx_r == IDX_W'(TABLE_SIZE - 1)) ? '0 : idx_r + 1'b1;

  // probe decision on the slot just read
  always_comb begin
    finish     = 1'b0;
    advance    = 1'b0;
    wr_slot    = 1'b0;
    wr_mark    = MARK_USED;
    res_status = ST_MISS;
    res_hit    = 1'b0;
    case (op_r)
      OP_SEARCH, OP_DELETE: begin
        if (rd_mark == MARK_EMPTY) begin
          finish = 1'b1;
        end else if (rd_mark == MARK_USED && ram_rdata.key == key_r) begin
          finish     = 1'b1;
          res_status = ST_OK;
          res_hit    = 1'b1;
          wr_slot    = (op_r == OP_DELETE);
          wr_mark    = MARK_TOMB;
        end else if (last) begin
          finish = 1'b1;
        end else begin
          advance = 1'b1;
        end
      end
      OP_INSERT: begin
        if (rd_mark != MARK_USED) begin
          finish     = 1'b1;
          res_status = ST_OK;
          wr_slot    = 1'b1;
          wr_mark    = MARK_USED;
        end else if (last) begin
          finish     = 1'b1;
          res_status = ST_FULL;
        end else begin
          advance = 1'b1;
        end
      end
      default: begin
        finish = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    ram_re     = 1'b0;
    ram_raddr  = idx_r;
    ram_we     = 1'b0;
    in_chan.ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          ram_re    = 1'b1;
          ram_raddr = home;
          idx_nxt   = home;
          cnt_nxt   = '0;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (advance) begin
          ram_re    = 1'b1;
          ram_raddr = idx_inc;
          idx_nxt   = idx_inc;
          cnt_nxt   = cnt_r + 1'b1;
        end else if (finish && out_free) begin
          ram_we    = wr_slot;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign ram_waddr       = idx_r;
  assign ram_wdata.mark  = wr_mark;
  // a delete keeps key and value, an insert writes the new pair
  assign ram_wdata.key   = (op_r == OP_INSERT) ? key_r : ram_rdata.key;
  assign ram_wdata.value = (op_r == OP_INSERT) ? val_r : ram_rdata.value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
      if (state_r == S_PROBE && finish && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    cnt_r <= cnt_nxt;
    if (accept) begin
      op_r  <= op_t'(in_chan.operation);
      key_r <= in_chan.lookup_key;
      val_r <= in_chan.entry_value;
    end
    if (ram_re) begin
      rd_vld_r <= vld_r[ram_raddr];
    end
    if (state_r == S_PROBE && finish && out_free) begin
      out_status_r <= res_status;
      out_key_r    <= res_hit ? ram_rdata.key : '0;
      out_val_r    <= res_hit ? ram_rdata.value : '0;
      out_slot_r   <= (res_status == ST_OK) ? SLOT_W'(idx_r) : '0;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.found_key   = out_key_r;
  assign out_chan.found_value = out_val_r;
  assign out_chan.slot_index  = out_slot_r;

endmodule

FILE: design/linear_probe_hash_table_top.sv
// Open-addressing hash table, linear probing, TABLE_SIZE (32) slots held in one
// synchronous RAM of {mark, key, value} words plus a per-slot written flag in flops,
// so reset leaves every slot empty with no clearing pass. One transaction is worked
// at a time: the accept cycle reads the home slot (key mod TABLE_SIZE) and each
// further cycle checks one slot while reading the next, as set by the single RAM
// read port; an item probes 1 to TABLE_SIZE slots, and its last slot waits while an
// untaken result holds the output register. The result then sits in that register;
// the next item is taken the cycle after, even while that result waits.
// Status: 0 done or found, 1 not found (also for operation code 3), 2 table full.
module linear_probe_hash_table_top import lpht_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  lpht_in_if.sink    in_chan,
  lpht_out_if.source out_chan
);

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  slot_t            ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  slot_t            ram_rdata;

  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  lpht_ram #(
    .DEPTH (TABLE_SIZE),
    .WIDTH (SLOT_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

FILE: design/lpht_checker.sv
module lpht_checker import lpht_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        out_status,
  input logic [KEY_W-1:0]  out_found_key,
  input logic [VAL_W-1:0]  out_found_value,
  input logic [SLOT_W-1:0] out_slot_index
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_slot_index))
    else $error("result dropped or changed while stalled");

  // one item in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in flight");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_MISS |->
      out_found_key == '0 && out_found_value == '0 && out_slot_index == '0)
    else $error("not-found result carries data");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |->
      out_found_key == '0 && out_found_value == '0 && out_slot_index == '0)
    else $error("table-full result carries data");

endmodule

bind linear_probe_hash_table_top lpht_checker u_lpht_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_status      (out_chan.status),
  .out_found_key   (out_chan.found_key),
  .out_found_value (out_chan.found_value),
  .out_slot_index  (out_chan.slot_index)
);

FILE: tb/sv/tb_linear_probe_hash_table_top.sv
`timescale 1ns / 1ps

module tb_linear_probe_hash_table_top;
  import lpht_pkg::*;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         WATCHDOG_LIMIT = 1000;
  localparam int         DRAIN_CYCLES   = 40;

  typedef struct {
    status_t                 status;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
    logic [SLOT_W-1:0]       slot;
  } lookup_result_t;

  class hash_table_scoreboard;
    mark_t                   slot_state [TABLE_SIZE];
    logic [KEY_W-1:0]        slot_key   [TABLE_SIZE];
    logic signed [VAL_W-1:0] slot_data  [TABLE_SIZE];
    lookup_result_t          expected_lookups [$];
    int                      op_count [4];
    int                      status_count [4];
    int                      results_seen;
    int                      mismatches;

    function new();
      foreach (slot_state[i]) slot_state[i] = MARK_EMPTY;
    endfunction

    // Walk the table the way the block does and queue the lookup result.
    function void note_request(logic [1:0] op, logic [KEY_W-1:0] key,
                               logic signed [VAL_W-1:0] val);
      lookup_result_t res;
      int             home;
      int             idx;
      int             hit;
      res  = '{status: ST_MISS, key: '0, value: '0, slot: '0};
      home = int'(key % TABLE_SIZE);
      hit  = -1;
      op_count[op]++;
      case (op)
        OP_SEARCH, OP_DELETE: begin
          // stop at the first empty slot; skip tombstones
          for (int n = 0; n < TABLE_SIZE; n++) begin
            idx = (home + n) % TABLE_SIZE;
            if (slot_state[idx] == MARK_EMPTY) break;
            if (slot_state[idx] == MARK_USED && slot_key[idx] == key) begin
              hit = idx;
              break;
            end
          end
          if (hit >= 0) begin
            res.status = ST_OK;
            res.key    = slot_key[hit];
            res.value  = slot_data[hit];
            res.slot   = SLOT_W'(hit);
            if (op == OP_DELETE) slot_state[hit] = MARK_TOMB;
          end
        end
        OP_INSERT: begin
          for (int n = 0; n < TABLE_SIZE; n++) begin
            idx = (home + n) % TABLE_SIZE;
            if (slot_state[idx] != MARK_USED) begin
              hit = idx;
              break;
            end
          end
          if (hit >= 0) begin
            slot_state[hit] = MARK_USED;
            slot_key[hit]   = key;
            slot_data[hit]  = val;
            res.status      = ST_OK;
            res.slot        = SLOT_W'(hit);
          end else begin
            res.status = ST_FULL;
          end
        end
        default: ;
      endcase
      expected_lookups.push_back(res);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("[%0t] MISMATCH result %0d: %s", $time, results_seen, what);
    endtask

    task check_response(logic [1:0] st, logic [KEY_W-1:0] key,
                        logic signed [VAL_W-1:0] val, logic [SLOT_W-1:0] slot);
      lookup_result_t want;
      results_seen++;
      status_count[st]++;
      if (expected_lookups.size() == 0) begin
        report_mismatch($sformatf("no result expected, got status %0d", st));
        return;
      end
      want = expected_lookups.pop_front();
      if (st !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", st, want.status));
      if (key !== want.key)
        report_mismatch($sformatf("found_key got 0x%08h want 0x%08h", key, want.key));
      if (val !== want.value)
        report_mismatch($sformatf("found_value got 0x%08h want 0x%08h", val, want.value));
      if (slot !== want.slot)
        report_mismatch($sformatf("slot_index got %0d want %0d", slot, want.slot));
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   idling_on;
  int   idle_cycles;

  hash_table_scoreboard sb;

  lpht_in_if  in_if ();
  lpht_out_if out_if ();

  linear_probe_hash_table_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Result side: random stall bursts while idling is on.
  initial begin
    int stall;
    stall = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 7);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Check results before noting requests so a same-edge pair stays ordered.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready)
        sb.check_response(out_if.status, out_if.found_key, out_if.found_value,
                          out_if.slot_index);
      if (in_if.valid && in_if.ready)
        sb.note_request(in_if.operation, in_if.lookup_key, in_if.entry_value);
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("[%0t] watchdog: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_item(input logic [1:0] op, input logic [KEY_W-1:0] key,
                           input logic signed [VAL_W-1:0] val);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.operation   <= op;
    in_if.lookup_key  <= key;
    in_if.entry_value <= val;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Favor keys already in the table and small colliding keys.
  function automatic logic [KEY_W-1:0] pick_key();
    int start;
    int sel;
    int idx;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      start = $urandom_range(0, TABLE_SIZE - 1);
      for (int n = 0; n < TABLE_SIZE; n++) begin
        idx = (start + n) % TABLE_SIZE;
        if (sb.slot_state[idx] == MARK_USED) return sb.slot_key[idx];
      end
    end
    if (sel < 80) return KEY_W'($urandom_range(0, 3 * TABLE_SIZE - 1));
    return KEY_W'($urandom);
  endfunction

  task automatic run_phase(input int count, input int insert_pct, input int delete_pct,
                           input bit with_idling);
    int         roll;
    logic [1:0] op;
    idling_on = with_idling;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 3)
        op = OP_UNUSED;
      else if (roll < 3 + insert_pct)
        op = OP_INSERT;
      else if (roll < 3 + insert_pct + delete_pct)
        op = OP_DELETE;
      else
        op = OP_SEARCH;
      send_item(op, pick_key(), VAL_W'($urandom));
    end
  endtask

  initial begin
    sb          = new();
    idling_on   = 1'b1;
    idle_cycles = 0;
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.operation   <= OP_SEARCH;
    in_if.lookup_key  <= '0;
    in_if.entry_value <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, unused code, extremes, collisions and wrap-around
    send_item(OP_SEARCH, 31'd5,          32'sd0);
    send_item(OP_UNUSED, 31'd0,          32'sd0);
    send_item(OP_INSERT, 31'd0,          32'sh8000_0000);
    send_item(OP_INSERT, 31'h7FFF_FFFF,  32'sh7FFF_FFFF);
    send_item(OP_INSERT, 31'd32,         -32'sd1);
    send_item(OP_INSERT, 31'h7FFF_FFDF,  32'sd0);
    send_item(OP_SEARCH, 31'h7FFF_FFDF,  32'sd0);
    send_item(OP_SEARCH, 31'd0,          32'sd0);
    // delete leaves a tombstone; searches must walk past it
    send_item(OP_DELETE, 31'd0,          32'sd0);
    send_item(OP_SEARCH, 31'd32,         32'sd0);
    send_item(OP_DELETE, 31'd0,          32'sd0);
    send_item(OP_INSERT, 31'd64,         32'sd12345);
    send_item(OP_SEARCH, 31'd64,         32'sd0);
    send_item(OP_UNUSED, 31'h7FFF_FFFF,  -32'sd1);
    send_item(OP_DELETE, 31'h7FFF_FFFF,  32'sd0);
    send_item(OP_SEARCH, 31'h7FFF_FFFF,  32'sd0);
    send_item(OP_SEARCH, 31'h2A5A_5A5A,  32'sh5A5A_5A5A);
    send_item(OP_DELETE, 31'd96,         32'sd0);
    send_item(OP_SEARCH, 31'h5555_5555,  32'shAAAA_AAAA);

    // fill past full, mix, drain to tombstones, refill, then a calm tail
    run_phase(100, 65, 15, 1'b1);
    run_phase(100, 30, 30, 1'b1);
    run_phase(100, 15, 60, 1'b1);
    run_phase(100, 70, 10, 1'b0);
    run_phase(100, 35, 35, 1'b1);
    run_phase(100, 40, 30, 1'b0);

    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d search, %0d insert, %0d delete, %0d unused code",
             sb.op_count[0] + sb.op_count[1] + sb.op_count[2] + sb.op_count[3],
             sb.op_count[OP_SEARCH], sb.op_count[OP_INSERT], sb.op_count[OP_DELETE],
             sb.op_count[OP_UNUSED]);
    $display("Checked %0d results: %0d done/found, %0d not found, %0d table full; %0d mismatches",
             sb.results_seen, sb.status_count[ST_OK], sb.status_count[ST_MISS],
             sb.status_count[ST_FULL], sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
